// File: hw/rtl/ipmf_pkg.sv
// shared types, constants and helpers of the ip mask filter table
`timescale 1ns / 1ps
`default_nettype none
package ipmf_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W      = 10;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // filter constants
   localparam logic [31:0] FREE_MARK = 32'hffff_ffff;
   localparam logic [7:0]  OCTET_ALL = 8'hff;

   // command codes on the request channel
   localparam logic [1:0] CMD_CHECK  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // status codes on the response channel
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // classified operation
   typedef enum logic [1:0] {
      OP_NONE,
      OP_CHECK,
      OP_ADD,
      OP_REMOVE
   } op_type;

   // one classified item as it travels through the queue
   typedef struct packed {
      op_type      op;
      logic [31:0] address;
      logic [31:0] pattern;
      logic [31:0] mask;
   } item_type;

   // nonzero octet gives an all-ones mask octet, zero octet is a wildcard
   function automatic logic [31:0] mask_of(input logic [31:0] pattern);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k < 4; k++) begin
         if (pattern[8*k +: 8] != 8'd0) begin
            m[8*k +: 8] = OCTET_ALL;
         end
      end
      return m;
   endfunction

   // low bits of an entry index as reported on the slot field
   function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ipmf_front.sv
// front end: accepts request items and classifies them for the queue
`timescale 1ns / 1ps
`default_nettype none
module ipmf_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [31:0]       req_address,
   input  wire logic [31:0]       req_pattern,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output ipmf_pkg::item_type     push_item
);
   import ipmf_pkg::*;

   // handshake passes straight to the queue
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // decode command and build the filter mask
   always_comb begin
      push_item.address = req_address;
      push_item.pattern = req_pattern;
      push_item.mask    = mask_of(req_pattern);
      case (req_command)
         CMD_CHECK:  push_item.op = OP_CHECK;
         CMD_ADD:    push_item.op = OP_ADD;
         CMD_REMOVE: push_item.op = OP_REMOVE;
         default:    push_item.op = OP_NONE;
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/ipmf_queue.sv
// small item queue between the front end and the scan engine
`timescale 1ns / 1ps
`default_nettype none
module ipmf_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire ipmf_pkg::item_type  push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output ipmf_pkg::item_type       pop_item
);
   import ipmf_pkg::*;

   item_type            storage_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                push;
   logic                pop;

   // occupancy flags
   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = storage_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= (QPTR_W + 1)'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= (QPTR_W + 1)'(count_ff - 1'b1);
         end
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/ipmf_back.sv
// scan engine: filter memory, one entry per cycle, and the response register
`timescale 1ns / 1ps
`default_nettype none
module ipmf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   input  wire ipmf_pkg::item_type          pop_item,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_reject,
   output logic [1:0]                       rsp_status,
   output logic [ipmf_pkg::SLOT_W-1:0]      rsp_slot
);
   import ipmf_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // filter memory
   logic [31:0]         mem_mask    [TABLE_DEPTH];
   logic [31:0]         mem_compare [TABLE_DEPTH];

   state_type           state_ff;
   item_type            cur_ff;
   logic [CNT_W-1:0]    issue_cnt_ff;
   logic                pend_valid_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [31:0]         rd_mask_ff;
   logic [31:0]         rd_compare_ff;
   logic [CNT_W-1:0]    used_count_ff;
   logic                ban_mode_ff;
   logic                rsp_valid_ff;
   logic                rsp_reject_ff;
   logic [1:0]          rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic                entry_free;
   logic                match;
   logic                hit;
   logic                scan_done;
   logic                out_free;
   logic                finish;
   logic                issue;
   logic                table_full;
   logic                res_reject;
   logic [1:0]          res_status;
   logic [IDX_W-1:0]    res_idx;
   logic                res_has_slot;
   logic                grow;
   logic                we_mask;
   logic                we_compare;
   logic [31:0]         wr_compare;

   assign pop_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_reject = rsp_reject_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   // compare the entry read in the previous cycle
   assign entry_free = (rd_compare_ff == FREE_MARK);
   always_comb begin
      case (cur_ff.op)
         OP_CHECK:  match = !entry_free && ((cur_ff.address & rd_mask_ff) == rd_compare_ff);
         OP_ADD:    match = entry_free;
         OP_REMOVE: match = (rd_mask_ff == cur_ff.mask) && (rd_compare_ff == cur_ff.pattern);
         default:   match = 1'b0;
      endcase
   end

   // scan control
   assign hit        = (state_ff == S_SCAN) && pend_valid_ff && match;
   assign scan_done  = (issue_cnt_ff >= used_count_ff) || (cur_ff.op == OP_NONE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == S_SCAN) && (hit || scan_done) && out_free;
   assign issue      = (state_ff == S_SCAN) && !hit && !scan_done;
   assign table_full = (used_count_ff == CNT_W'(TABLE_DEPTH));

   // result and table update for the finishing item
   always_comb begin
      res_reject   = 1'b0;
      res_status   = ST_DONE;
      res_idx      = pend_idx_ff;
      res_has_slot = 1'b0;
      grow         = 1'b0;
      we_mask      = 1'b0;
      we_compare   = 1'b0;
      wr_compare   = cur_ff.pattern;
      case (cur_ff.op)
         OP_CHECK: begin
            res_reject = hit ? ban_mode_ff : !ban_mode_ff;
         end
         OP_ADD: begin
            if (hit) begin
               res_has_slot = 1'b1;
               we_mask      = finish;
               we_compare   = finish;
            end else if (table_full) begin
               res_status = ST_FULL;
            end else begin
               res_idx      = used_count_ff[IDX_W-1:0];
               res_has_slot = 1'b1;
               grow         = 1'b1;
               we_mask      = finish;
               we_compare   = finish;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               res_has_slot = 1'b1;
               we_compare   = finish;
               wr_compare   = FREE_MARK;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: begin
            res_reject = 1'b0;
         end
      endcase
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (we_mask) begin
         mem_mask[res_idx] <= cur_ff.mask;
      end
      if (we_compare) begin
         mem_compare[res_idx] <= wr_compare;
      end
      if (issue) begin
         rd_mask_ff    <= mem_mask[issue_cnt_ff[IDX_W-1:0]];
         rd_compare_ff <= mem_compare[issue_cnt_ff[IDX_W-1:0]];
      end
   end

   // state machine, count, mode and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         used_count_ff <= '0;
         ban_mode_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ban_mode_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  cur_ff        <= pop_item;
                  issue_cnt_ff  <= '0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (finish) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_reject_ff <= res_reject;
                  rsp_status_ff <= res_status;
                  rsp_slot_ff   <= res_has_slot ? slot_of(res_idx) : '0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
                  if (grow) begin
                     used_count_ff <= CNT_W'(used_count_ff + 1'b1);
                  end
               end else if (issue) begin
                  pend_valid_ff <= 1'b1;
                  pend_idx_ff   <= issue_cnt_ff[IDX_W-1:0];
                  issue_cnt_ff  <= CNT_W'(issue_cnt_ff + 1'b1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("used count above table depth");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> used_count_ff >= $past(used_count_ff))
      else $error("used count shrank");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> table_full)
      else $error("full reported with free room");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (issue_cnt_ff <= used_count_ff))
      else $error("scan ran past used entries");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/ip_mask_filter_table_core.sv
// top level of the ip mask filter table: front end, queue and scan engine
// Usage:
//   req channel (valid/ready) takes one item: command (check, add, remove),
//   address to check and filter pattern. rsp channel (valid/ready) returns
//   exactly one item per request: reject, status and slot, in request order.
//   csr_wr_en/csr_wr_data write the ban mode bit (1 ban, 0 allow list);
//   write it only while no item is in flight.
// Scan:
//   an item passes through the queue, then the engine reads one filter entry
//   per cycle up to the used count and compares each entry in the cycle after
//   it is read; a hit ends the scan early. The engine takes a new item only
//   after the last one has finished; the two-entry queue takes new items while
//   it scans.
// Reset:
//   synchronous; clears the used count, the queue and the response valid,
//   and sets ban mode. The filter memory itself is not cleared.
// Stall:
//   while rsp_ready is low a finished result holds in the response register
//   and the engine waits; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
`default_nettype none
module ip_mask_filter_table_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [1:0]                  req_command,
   input  wire logic [31:0]                 req_address,
   input  wire logic [31:0]                 req_pattern,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_reject,
   output logic [1:0]                       rsp_status,
   output logic [ipmf_pkg::SLOT_W-1:0]      rsp_slot,
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data
);
   import ipmf_pkg::*;

   logic       push_valid;
   logic       push_ready;
   item_type   push_item;
   logic       pop_valid;
   logic       pop_ready;
   item_type   pop_item;

   // classify incoming items
   ipmf_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_address (req_address),
      .req_pattern (req_pattern),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // decouple front end from scan engine
   ipmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // scan the table and answer
   ipmf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_reject  (rsp_reject),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot)
   );

endmodule
`default_nettype wire

// File: sim/ip_mask_filter_table_checker.sv
// checker for the ip mask filter table: watches both channels, predicts and compares
`timescale 1ns / 1ps
module ip_mask_filter_table_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [1:0]                    req_command,
   input  wire logic [31:0]                   req_address,
   input  wire logic [31:0]                   req_pattern,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          rsp_reject,
   input  wire logic [1:0]                    rsp_status,
   input  wire logic [ipmf_pkg::SLOT_W-1:0]   rsp_slot,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data,
   output int                                 fail_count,
   output int                                 replies_pending,
   output int                                 reject_total,
   output int                                 full_total,
   output int                                 not_found_total,
   output int                                 peak_used
);
   import ipmf_pkg::*;

   // one reply item as seen on the rsp channel
   typedef struct packed {
      logic              reject;
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
   } reply_type;

   // shadow filter table
   logic [31:0] shadow_mask [TABLE_DEPTH];
   logic [31:0] shadow_cmp  [TABLE_DEPTH];
   int unsigned shadow_used;
   logic        shadow_ban;

   reply_type   replies_due [$];
   int          errors;
   int          rejects;
   int          fulls;
   int          misses;

   // wildcard octets give a zero mask octet, all others all ones
   function automatic logic [31:0] octet_mask(input logic [31:0] p);
      return {{8{|p[31:24]}}, {8{|p[23:16]}}, {8{|p[15:8]}}, {8{|p[7:0]}}};
   endfunction

   // run one command against the shadow table and return its reply
   function automatic reply_type filter_table_reply(input logic [1:0]  cmd,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] pat);
      reply_type   r;
      logic [31:0] m;
      int unsigned n;
      int unsigned i;
      logic        hit;
      r   = '0;
      n   = shadow_used;
      m   = octet_mask(pat);
      hit = 1'b0;
      case (cmd)
         CMD_CHECK: begin
            // free entries never match
            for (i = 0; i < n && !hit; i++) begin
               if (shadow_cmp[i] != FREE_MARK && (addr & shadow_mask[i]) == shadow_cmp[i]) begin
                  hit = 1'b1;
               end
            end
            r.reject = hit ? shadow_ban : !shadow_ban;
         end
         CMD_ADD: begin
            // first free entry, else append, else full
            i = 0;
            while (i < n && shadow_cmp[i] != FREE_MARK) begin
               i++;
            end
            if (i == TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (i == n) begin
                  shadow_used = n + 1;
               end
               shadow_mask[i] = m;
               shadow_cmp[i]  = pat;
               r.slot         = SLOT_W'(i);
            end
         end
         CMD_REMOVE: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < n && r.status == ST_NOT_FOUND; i++) begin
               if (shadow_mask[i] == m && shadow_cmp[i] == pat) begin
                  shadow_cmp[i] = FREE_MARK;
                  r.status      = ST_DONE;
                  r.slot        = SLOT_W'(i);
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // predict on accepted requests, compare on accepted replies
   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         shadow_used = 0;
         shadow_ban  = 1'b1;
         replies_due.delete();
         errors  = 0;
         rejects = 0;
         fulls   = 0;
         misses  = 0;
      end else begin
         if (csr_wr_en) begin
            shadow_ban = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            want = filter_table_reply(req_command, req_address, req_pattern);
            replies_due.push_back(want);
            if (want.reject) rejects++;
            if (want.status == ST_FULL) fulls++;
            if (want.status == ST_NOT_FOUND) misses++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_reject, rsp_status, rsp_slot};
            if (replies_due.size() == 0) begin
               $display("%0t: reply with none expected: reject %0b status %0d slot %0d",
                        $time, got.reject, got.status, got.slot);
               errors++;
            end else begin
               want = replies_due.pop_front();
               if (got.reject != want.reject) begin
                  $display("%0t: reject expected %0b actual %0b",
                           $time, want.reject, got.reject);
                  errors++;
               end
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.slot != want.slot) begin
                  $display("%0t: slot expected %0d actual %0d",
                           $time, want.slot, got.slot);
                  errors++;
               end
            end
         end
      end
      fail_count      <= errors;
      replies_pending <= replies_due.size();
      reject_total    <= rejects;
      full_total      <= fulls;
      not_found_total <= misses;
      peak_used       <= shadow_used;
   end

endmodule

// File: sim/tb_ip_mask_filter_table_core.sv
// testbench top for the ip mask filter table: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_ip_mask_filter_table_core;
   import ipmf_pkg::*;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         RESET_CYCLES   = 5;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         WATCHDOG_LIMIT = 6000;
   localparam int         SETTLE_CYCLES  = TABLE_DEPTH + 8;
   localparam int         POOL_SIZE      = 16;
   localparam int         PHASES         = 5;
   localparam int         PHASE_ITEMS    = 109;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command = CMD_CHECK;
   logic [31:0]       req_address = '0;
   logic [31:0]       req_pattern = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic              rsp_reject;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_slot;
   logic              csr_wr_en   = 1'b0;
   logic              csr_wr_data = 1'b0;

   int fail_count;
   int replies_pending;
   int reject_total;
   int full_total;
   int not_found_total;
   int peak_used;

   int          stall_odds    = 0;
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          idle_cycles   = 0;
   int          sent_per_cmd [4] = '{default: 0};
   int          phase_odds [PHASES] = '{25, 0, 40, 60, 0};
   logic [31:0] pattern_pool [POOL_SIZE];

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ip_mask_filter_table_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_address (req_address),
      .req_pattern (req_pattern),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_reject  (rsp_reject),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ip_mask_filter_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_pattern     (req_pattern),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reject      (rsp_reject),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .replies_pending (replies_pending),
      .reject_total    (reject_total),
      .full_total      (full_total),
      .not_found_total (not_found_total),
      .peak_used       (peak_used)
   );

   // watchdog: cycles without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("ip_mask_filter_table_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: long hold-off on request, random stall bursts otherwise
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_served != hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end else if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // pattern with some wildcard octets
   function automatic logic [31:0] random_pattern();
      logic [31:0] p;
      for (int k = 0; k < 4; k++) begin
         p[8*k +: 8] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      end
      return p;
   endfunction

   // address that the given pattern's filter matches
   function automatic logic [31:0] covering_address(input logic [31:0] pat);
      logic [31:0] a;
      a = $urandom();
      for (int k = 0; k < 4; k++) begin
         if (pat[8*k +: 8] != 8'd0) a[8*k +: 8] = pat[8*k +: 8];
      end
      return a;
   endfunction

   // offer one item, keeping valid high into the next one when there is no gap
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] addr,
                            input logic [31:0] pat);
      int gap;
      gap = 0;
      if (stall_odds > 0 && $urandom_range(0, 99) < stall_odds) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_pattern <= pat;
      do @(posedge clock); while (!req_ready);
      sent_per_cmd[cmd]++;
   endtask

   // stop offering and wait until every reply has come back
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
   endtask

   // ban mode is written only with the table idle
   task automatic write_ban_mode(input logic value);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly pool patterns so adds, removes and checks meet each other
   task automatic random_item();
      int          pick;
      logic [31:0] pat;
      pick = $urandom_range(0, 99);
      pat  = pattern_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 45) begin
         if ($urandom_range(0, 1) == 1) send_item(CMD_CHECK, covering_address(pat), $urandom());
         else send_item(CMD_CHECK, $urandom(), $urandom());
      end else if (pick < 65) begin
         send_item(CMD_ADD, $urandom(), pat);
      end else if (pick < 70) begin
         send_item(CMD_ADD, $urandom(), $urandom());
      end else if (pick < 93) begin
         if ($urandom_range(0, 3) != 0) send_item(CMD_REMOVE, $urandom(), pat);
         else send_item(CMD_REMOVE, $urandom(), random_pattern());
      end else begin
         send_item(CMD_UNUSED, $urandom(), $urandom());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, free marks, reuse, ban and allow lists
      stall_odds = 20;
      send_item(CMD_CHECK,  32'h0000_0000, 32'h0000_0000);
      send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0102_0304);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ADD,    32'h0000_0000, 32'h0A00_0000);
      send_item(CMD_ADD,    32'h0000_0000, 32'hC0A8_0101);
      // all-ones filter is free as soon as it is written
      send_item(CMD_ADD,    32'h0000_0000, FREE_MARK);
      send_item(CMD_ADD,    32'h0000_0000, 32'h00FF_0000);
      send_item(CMD_CHECK,  32'h0A12_3456, 32'h0000_0000);
      send_item(CMD_CHECK,  FREE_MARK,     32'h0000_0000);
      send_item(CMD_CHECK,  32'h0102_0304, 32'h0000_0000);
      // remove of all ones lands on the free entry and leaves it free
      send_item(CMD_ADD,    32'h0000_0000, FREE_MARK);
      send_item(CMD_REMOVE, 32'h0000_0000, FREE_MARK);
      send_item(CMD_ADD,    32'h0000_0000, 32'h0000_00FF);
      send_item(CMD_CHECK,  32'h1234_56FF, 32'h0000_0000);
      send_item(CMD_REMOVE, 32'h0000_0000, 32'h0A00_0000);
      send_item(CMD_CHECK,  32'h0A00_0001, 32'h0000_0000);
      send_item(CMD_REMOVE, 32'h0000_0000, 32'h0A00_0000);
      write_ban_mode(1'b0);
      send_item(CMD_CHECK,  32'hC0A8_0101, 32'h0000_0000);
      send_item(CMD_CHECK,  32'h0B00_0000, 32'h0000_0000);
      // all-wildcard filter matches every address
      send_item(CMD_ADD,    32'h0000_0000, 32'h0000_0000);
      send_item(CMD_CHECK,  32'h0B00_0000, 32'h0000_0000);
      send_item(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_CHECK,  FREE_MARK,     FREE_MARK);

      // random phases, each with its own mode, pattern pool and stall rate
      for (int p = 0; p < PHASES; p++) begin
         write_ban_mode(p[0]);
         stall_odds = phase_odds[p];
         pattern_pool[0] = FREE_MARK;
         for (int k = 1; k < POOL_SIZE; k++) pattern_pool[k] = random_pattern();
         if (p == 3) pattern_pool[1] = '0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // receiver holds off while the sender keeps the input busy
            if (p == 1 && n == 40) begin
               hold_requests++;
               repeat (12) random_item();
            end
            random_item();
         end
      end

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d checks, %0d adds, %0d removes, %0d unused codes; %0d refused",
               sent_per_cmd[CMD_CHECK], sent_per_cmd[CMD_ADD], sent_per_cmd[CMD_REMOVE],
               sent_per_cmd[CMD_UNUSED], reject_total);
      $display("table full %0d times, remove missed %0d times, %0d of %0d entries taken",
               full_total, not_found_total, peak_used, TABLE_DEPTH);
      if (fail_count == 0 && replies_pending == 0) begin
         $display("ip_mask_filter_table_core verification clean");
      end else begin
         $display("ip_mask_filter_table_core verification failed");
      end
      $finish;
   end

endmodule
